>>> hdl/sti_pkg.sv
// shared types and constants of the sorted table
`default_nettype none

package sti_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 3;
    localparam int COUNT_W   = 5;

    typedef enum logic
    {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } sti_req_t;

    typedef enum logic [STATUS_W-1:0]
    {
        STS_INSERTED  = 3'd0,
        STS_REMOVED   = 3'd1,
        STS_NOT_FOUND = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_FULL      = 3'd4
    } sti_status_t;

    typedef enum logic
    {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } sti_state_t;

    typedef struct packed
    {
        logic load;
        logic exec;
    } sti_cmd_t;

endpackage

`default_nettype wire

>>> hdl/sti_if.sv
// request and response channel interfaces
`default_nettype none

interface sti_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [sti_pkg::VALUE_W-1:0]  item_value;

    modport source (output valid, output req_type, output item_value, input ready);
    modport sink   (input valid, input req_type, input item_value, output ready);
endinterface

interface sti_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sti_pkg::STATUS_W-1:0]        status;
    logic [sti_pkg::COUNT_W-1:0]         entry_count;
    logic signed [sti_pkg::VALUE_W-1:0]  smallest_value;
    logic                                smallest_valid;

    modport source (output valid, output status, output entry_count,
                    output smallest_value, output smallest_valid, input ready);
    modport sink   (input valid, input status, input entry_count,
                    input smallest_value, input smallest_valid, output ready);
endinterface

`default_nettype wire

>>> hdl/sti_ctrl.sv
// controller: sequences request load, table update and response handoff
`default_nettype none

module sti_ctrl
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output sti_pkg::sti_cmd_t      cmd
);

    sti_pkg::sti_state_t state_reg;
    sti_pkg::sti_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sti_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sti_pkg::ST_EXEC;
                end
            end
            sti_pkg::ST_EXEC:
            begin
                if (slot_free)
                begin
                    state_next = sti_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sti_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            sti_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            sti_pkg::ST_EXEC:
            begin
                cmd.exec = slot_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sti_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/sti_dp.sv
// datapath: row of sorted cells with parallel compares and shift update
`default_nettype none

module sti_dp
#(
    parameter int DEPTH = sti_pkg::DEPTH_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire sti_pkg::sti_cmd_t                  cmd,
    input  wire logic                               in_req_type,
    input  wire logic signed [sti_pkg::VALUE_W-1:0] in_item_value,
    output logic [sti_pkg::STATUS_W-1:0]            out_status,
    output logic [sti_pkg::COUNT_W-1:0]             out_entry_count,
    output logic signed [sti_pkg::VALUE_W-1:0]      out_smallest_value,
    output logic                                    out_smallest_valid
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [sti_pkg::VALUE_W-1:0] entry_reg [DEPTH];
    logic signed [sti_pkg::VALUE_W-1:0] entry_next [DEPTH];
    logic [CNT_W-1:0]                   count_reg;
    logic [CNT_W-1:0]                   count_next;
    logic                               op_type_reg;
    logic signed [sti_pkg::VALUE_W-1:0] op_value_reg;

    logic [sti_pkg::STATUS_W-1:0]       status_reg;
    logic [sti_pkg::COUNT_W-1:0]        ecount_reg;
    logic signed [sti_pkg::VALUE_W-1:0] small_reg;
    logic                               small_valid_reg;

    logic [DEPTH-1:0]                   lt;
    logic [DEPTH-1:0]                   eq;
    logic                               found;
    logic                               full;
    logic                               empty;
    logic                               is_remove;
    logic                               commit;
    sti_pkg::sti_status_t               status_next;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic cell_valid;
            logic signed [sti_pkg::VALUE_W-1:0] ins_val;
            logic signed [sti_pkg::VALUE_W-1:0] rem_val;

            assign cell_valid = CNT_W'(gi) < count_reg;
            assign lt[gi] = cell_valid && (entry_reg[gi] < op_value_reg);
            assign eq[gi] = cell_valid && (entry_reg[gi] == op_value_reg);

            if (gi == 0)
            begin : g_first
                assign ins_val = lt[gi] ? entry_reg[gi] : op_value_reg;
            end
            else
            begin : g_rest
                assign ins_val = lt[gi]     ? entry_reg[gi] :
                                 lt[gi - 1] ? op_value_reg  : entry_reg[gi - 1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign rem_val = entry_reg[gi];
            end
            else
            begin : g_mid
                // cells at or past the first match pull from the right
                assign rem_val = (cell_valid && !lt[gi]) ? entry_reg[gi + 1] : entry_reg[gi];
            end

            assign entry_next[gi] = is_remove ? rem_val : ins_val;

            always_ff @(posedge clk)
            begin
                if (commit)
                begin
                    entry_reg[gi] <= entry_next[gi];
                end
            end
        end
    endgenerate

    assign is_remove = (op_type_reg == sti_pkg::REQ_REMOVE);
    assign found     = |eq;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        commit      = 1'b0;
        count_next  = count_reg;
        status_next = sti_pkg::STS_INSERTED;
        if (is_remove)
        begin
            if (empty)
            begin
                status_next = sti_pkg::STS_EMPTY;
            end
            else if (found)
            begin
                status_next = sti_pkg::STS_REMOVED;
                commit      = cmd.exec;
                count_next  = count_reg - CNT_W'(1);
            end
            else
            begin
                status_next = sti_pkg::STS_NOT_FOUND;
            end
        end
        else
        begin
            if (full)
            begin
                status_next = sti_pkg::STS_FULL;
            end
            else
            begin
                status_next = sti_pkg::STS_INSERTED;
                commit      = cmd.exec;
                count_next  = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_type_reg  <= in_req_type;
            op_value_reg <= in_item_value;
        end
        if (cmd.exec)
        begin
            status_reg      <= status_next;
            ecount_reg      <= sti_pkg::COUNT_W'(count_next);
            small_valid_reg <= (count_next != '0);
            if (count_next == '0)
            begin
                small_reg <= '0;
            end
            else if (commit)
            begin
                small_reg <= entry_next[0];
            end
            else
            begin
                small_reg <= entry_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign out_status         = status_reg;
    assign out_entry_count    = ecount_reg;
    assign out_smallest_value = small_reg;
    assign out_smallest_valid = small_valid_reg;

endmodule

`default_nettype wire

>>> hdl/sorted_table_insert_remove.sv
// top level: sorted table with insert and remove requests
// the request is loaded into the operand registers, the table updates in the exec
// state once the response slot is free, and the response is then registered valid;
// the controller takes a new request only after its load and update steps are done
// and the table update writes all cells together; a waiting response holds the table update of the next request only
// reset: asynchronous active low, empties the table and drops any response
`default_nettype none

module sorted_table_insert_remove
#(
    parameter int DEPTH = sti_pkg::DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    sti_req_if.sink    req,
    sti_rsp_if.source  rsp
);

    sti_pkg::sti_cmd_t cmd;

    sti_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    sti_dp #(.DEPTH(DEPTH)) u_dp
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .in_req_type        (req.req_type),
        .in_item_value      (req.item_value),
        .out_status         (rsp.status),
        .out_entry_count    (rsp.entry_count),
        .out_smallest_value (rsp.smallest_value),
        .out_smallest_valid (rsp.smallest_valid)
    );

endmodule

`default_nettype wire

>>> hdl/sti_chk.sv
// port checker for the sorted table and its bind
`default_nettype none

module sti_chk
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               req_valid,
    input wire logic                               req_ready,
    input wire logic                               rsp_valid,
    input wire logic                               rsp_ready,
    input wire logic [sti_pkg::STATUS_W-1:0]       status,
    input wire logic [sti_pkg::COUNT_W-1:0]        entry_count,
    input wire logic signed [sti_pkg::VALUE_W-1:0] smallest_value,
    input wire logic                               smallest_valid
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status)
            && $stable(entry_count) && $stable(smallest_value) && $stable(smallest_valid))
        else $error("response changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> smallest_valid == (entry_count != '0))
        else $error("smallest_valid disagrees with entry_count");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == sti_pkg::STS_EMPTY |-> entry_count == '0
            && smallest_value == '0)
        else $error("remove on empty with entries held");

    a_insert_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == sti_pkg::STS_INSERTED |-> smallest_valid)
        else $error("insert left table empty");

endmodule

bind sorted_table_insert_remove sti_chk u_sti_chk
(
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .entry_count    (rsp.entry_count),
    .smallest_value (rsp.smallest_value),
    .smallest_valid (rsp.smallest_valid)
);

`default_nettype wire

>>> test/sorted_table_insert_remove_tb.sv
// testbench for the sorted table: random and directed insert and remove requests checked
`timescale 1ns / 100ps

module sorted_table_insert_remove_tb;

    localparam int TABLE_DEPTH = sti_pkg::DEPTH_DEF;
    localparam int RANDOM_ITEMS = 930;
    localparam int CALM_TAIL = 150;
    localparam int BLOCK_ITEMS = 40;
    localparam int STALL_LIMIT = 2000;
    localparam logic signed [sti_pkg::VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
    localparam logic signed [sti_pkg::VALUE_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;

    typedef struct packed
    {
        sti_pkg::sti_status_t               status;
        logic [sti_pkg::COUNT_W-1:0]        entry_count;
        logic signed [sti_pkg::VALUE_W-1:0] smallest_value;
        logic                               smallest_valid;
    } response_t;

    class sorted_table_scoreboard;
        logic signed [sti_pkg::VALUE_W-1:0] entries [TABLE_DEPTH];
        int                                 held;
        response_t                          expected_responses [$];
        int                                 mismatches;

        function new();
            held = 0;
            mismatches = 0;
        endfunction

        function void note_request(sti_pkg::sti_req_t kind,
                                   logic signed [sti_pkg::VALUE_W-1:0] value);
            response_t rsp;
            int        pos;
            int        i;
            pos = 0;
            if (kind == sti_pkg::REQ_INSERT)
            begin
                if (held >= TABLE_DEPTH)
                begin
                    rsp.status = sti_pkg::STS_FULL;
                end
                else
                begin
                    while (pos < held && entries[pos] < value)
                        pos++;
                    for (i = held; i > pos; i--)
                        entries[i] = entries[i - 1];
                    entries[pos] = value;
                    held++;
                    rsp.status = sti_pkg::STS_INSERTED;
                end
            end
            else
            begin
                if (held == 0)
                begin
                    rsp.status = sti_pkg::STS_EMPTY;
                end
                else
                begin
                    while (pos < held && entries[pos] != value)
                        pos++;
                    if (pos >= held)
                    begin
                        rsp.status = sti_pkg::STS_NOT_FOUND;
                    end
                    else
                    begin
                        for (i = pos; i + 1 < held; i++)
                            entries[i] = entries[i + 1];
                        held--;
                        rsp.status = sti_pkg::STS_REMOVED;
                    end
                end
            end
            rsp.entry_count = sti_pkg::COUNT_W'(held);
            rsp.smallest_valid = (held > 0);
            rsp.smallest_value = (held > 0) ? entries[0] : '0;
            expected_responses.push_back(rsp);
        endfunction

        task report_mismatch(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_response(response_t got);
            response_t want;
            if (expected_responses.size() == 0)
            begin
                report_mismatch("response with no request waiting");
            end
            else
            begin
                want = expected_responses.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0d expected %0d",
                                              got.status, want.status));
                if (got.entry_count !== want.entry_count)
                    report_mismatch($sformatf("entry_count got %0d expected %0d",
                                              got.entry_count, want.entry_count));
                if (got.smallest_value !== want.smallest_value)
                    report_mismatch($sformatf("smallest_value got %0d expected %0d",
                                              got.smallest_value, want.smallest_value));
                if (got.smallest_valid !== want.smallest_valid)
                    report_mismatch($sformatf("smallest_valid got %0b expected %0b",
                                              got.smallest_valid, want.smallest_valid));
            end
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   idling_on;
    int   gap_chance;
    int   quiet_cycles;

    sorted_table_scoreboard board;

    sti_req_if req_if ();
    sti_rsp_if rsp_if ();

    sorted_table_insert_remove #(.DEPTH(TABLE_DEPTH)) uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task send_request(sti_pkg::sti_req_t kind, logic signed [sti_pkg::VALUE_W-1:0] value);
        if (idling_on && gap_chance > 0 && $urandom_range(0, 9) < gap_chance)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= kind;
        req_if.item_value <= value;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        board.note_request(kind, value);
    endtask

    function automatic logic signed [sti_pkg::VALUE_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return sti_pkg::VALUE_W'($signed($urandom_range(0, 9)) - 4);
        else if (roll < 62)
            case ($urandom_range(0, 3))
                0: return MIN_VALUE;
                1: return MAX_VALUE;
                2: return '0;
                default: return -1;
            endcase
        else
            return $urandom;
    endfunction

    // response side: random stall bursts while idling is on
    initial
    begin
        int stall_left;
        response_t got;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                got.status = sti_pkg::sti_status_t'(rsp_if.status);
                got.entry_count = rsp_if.entry_count;
                got.smallest_value = rsp_if.smallest_value;
                got.smallest_valid = rsp_if.smallest_valid;
                board.check_response(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (idling_on && gap_chance > 0 && $urandom_range(0, 9) < gap_chance)
            begin
                stall_left = $urandom_range(1, 6) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        quiet_cycles = 0;
        @(posedge rst_n);
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int n;
        int insert_pct;
        sti_pkg::sti_req_t kind;
        logic signed [sti_pkg::VALUE_W-1:0] value;

        board = new();
        idling_on = 1'b1;
        gap_chance = 3;
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.req_type <= sti_pkg::REQ_INSERT;
        req_if.item_value <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, extremes, duplicates, misses, drain to empty
        send_request(sti_pkg::REQ_REMOVE, 32'sd5);
        send_request(sti_pkg::REQ_INSERT, MAX_VALUE);
        send_request(sti_pkg::REQ_INSERT, MIN_VALUE);
        send_request(sti_pkg::REQ_INSERT, 32'sd0);
        send_request(sti_pkg::REQ_INSERT, -32'sd1);
        send_request(sti_pkg::REQ_INSERT, 32'sd0);
        send_request(sti_pkg::REQ_INSERT, 32'sd1);
        send_request(sti_pkg::REQ_REMOVE, 32'sd7);
        send_request(sti_pkg::REQ_REMOVE, MIN_VALUE);
        send_request(sti_pkg::REQ_REMOVE, 32'sd0);
        send_request(sti_pkg::REQ_REMOVE, 32'sd0);
        send_request(sti_pkg::REQ_REMOVE, MAX_VALUE);
        send_request(sti_pkg::REQ_REMOVE, -32'sd1);
        send_request(sti_pkg::REQ_REMOVE, 32'sd1);
        send_request(sti_pkg::REQ_REMOVE, 32'sd0);
        send_request(sti_pkg::REQ_INSERT, 32'sh5555_5555);
        send_request(sti_pkg::REQ_INSERT, 32'shAAAA_AAAA);
        send_request(sti_pkg::REQ_REMOVE, 32'sh5555_5555);
        send_request(sti_pkg::REQ_REMOVE, 32'shAAAA_AAAA);

        // random: blocks alternate between filling and draining the table
        insert_pct = 80;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % BLOCK_ITEMS == 0)
            begin
                insert_pct = ((n / BLOCK_ITEMS) % 2 == 0) ? 80 : 25;
                gap_chance = $urandom_range(0, 4);
            end
            if (n == RANDOM_ITEMS - CALM_TAIL)
                idling_on = 1'b0;
            kind = ($urandom_range(0, 99) < insert_pct) ? sti_pkg::REQ_INSERT
                                                        : sti_pkg::REQ_REMOVE;
            if (kind == sti_pkg::REQ_REMOVE && board.held > 0 && $urandom_range(0, 9) < 6)
                value = board.entries[$urandom_range(0, board.held - 1)];
            else
                value = pick_value();
            send_request(kind, value);
        end
        req_if.valid <= 1'b0;

        while (board.expected_responses.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (board.mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> files.f
hdl/sti_pkg.sv
hdl/sti_if.sv
hdl/sti_ctrl.sv
hdl/sti_dp.sv
hdl/sorted_table_insert_remove.sv
hdl/sti_chk.sv
test/sorted_table_insert_remove_tb.sv
